// ===== hw/rtl/tlce_pkg.sv =====
package tlce_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } t_state;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_CHAR  = 2'd3;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_ASCII   = 3'd1;
    localparam logic [2:0] CMD_TABLE   = 3'd2;
    localparam logic [2:0] CMD_MISSING = 3'd3;
    localparam logic [2:0] CMD_STOPPED = 3'd4;
    localparam logic [2:0] CMD_FULL    = 3'd5;

    localparam logic [2:0] CFG_SCREEN_W = 3'd0;
    localparam logic [2:0] CFG_SCREEN_H = 3'd1;
    localparam logic [2:0] CFG_ASCII_W  = 3'd2;
    localparam logic [2:0] CFG_ASCII_H  = 3'd3;
    localparam logic [2:0] CFG_WIDE_W   = 3'd4;
    localparam logic [2:0] CFG_WIDE_H   = 3'd5;

    localparam logic [7:0]  CHAR_LF    = 8'h0A;
    localparam logic [7:0]  CHAR_FIRST = 8'h20;
    localparam logic [7:0]  CHAR_LAST  = 8'h7E;
    localparam logic [10:0] CUR_MAX    = 11'd2047;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic scan;
        logic finish;
    } t_ctl;

    typedef struct packed {
        logic is_wide;
        logic scan_done;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [2:0]  command;
        logic [10:0] draw_x;
        logic [10:0] draw_y;
        logic [6:0]  glyph_width;
        logic [6:0]  glyph_height;
        logic [6:0]  glyph_index;
        logic [2:0]  bytes_consumed;
        logic [10:0] end_x;
        logic [10:0] end_y;
    } t_result;

    function automatic logic [10:0] sat_add(input logic [10:0] a, input logic [10:0] b);
        logic [11:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[11] ? CUR_MAX : s[10:0];
    endfunction

endpackage

// ===== hw/rtl/tlce_ctrl.sv =====
module tlce_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tlce_pkg::t_sts i_sts,
    output tlce_pkg::t_ctl o_ctl
);

    tlce_pkg::t_state r_state;
    tlce_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlce_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tlce_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tlce_pkg::ST_EXEC;
                end
            end
            tlce_pkg::ST_EXEC: begin
                if (i_sts.is_wide) begin
                    n_state = tlce_pkg::ST_SCAN;
                end else if (i_sts.out_free) begin
                    n_state = tlce_pkg::ST_IDLE;
                end
            end
            tlce_pkg::ST_SCAN: begin
                if (i_sts.scan_done && i_sts.out_free) begin
                    n_state = tlce_pkg::ST_IDLE;
                end
            end
            default: n_state = tlce_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_ctl      = '0;
        case (r_state)
            tlce_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_ctl.load_item = i_in_valid;
            end
            tlce_pkg::ST_EXEC: begin
                o_ctl.exec = i_sts.is_wide || i_sts.out_free;
            end
            tlce_pkg::ST_SCAN: begin
                o_ctl.scan   = 1'b1;
                o_ctl.finish = i_sts.scan_done && i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tlce_dp.sv =====
module tlce_dp #(
    parameter int KEY_ENTRIES   = 64,
    parameter int KEY_MAX_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlce_pkg::t_ctl    i_ctl,
    output tlce_pkg::t_sts    o_sts,
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_index,
    input  logic [10:0]       i_cfg_data,
    input  logic [1:0]        i_action,
    input  logic [10:0]       i_origin_x,
    input  logic [10:0]       i_origin_y,
    input  logic [10:0]       i_area_width,
    input  logic [2:0]        i_key_length,
    input  logic [7:0]        i_byte_0,
    input  logic [7:0]        i_byte_1,
    input  logic [7:0]        i_byte_2,
    input  logic [7:0]        i_byte_3,
    input  logic [2:0]        i_window_length,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output tlce_pkg::t_result o_res
);

    localparam int KW   = $clog2(KEY_ENTRIES + 1);
    localparam int AW   = (KEY_ENTRIES > 1) ? $clog2(KEY_ENTRIES) : 1;
    localparam int KCAP = (KEY_MAX_BYTES < 4) ? KEY_MAX_BYTES : 4;

    // configuration
    logic [10:0] r_screen_w, r_screen_h;
    logic [6:0]  r_ascii_w, r_ascii_h, r_wide_w, r_wide_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= 11'd240;
            r_screen_h <= 11'd320;
            r_ascii_w  <= 7'd8;
            r_ascii_h  <= 7'd16;
            r_wide_w   <= 7'd16;
            r_wide_h   <= 7'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tlce_pkg::CFG_SCREEN_W: r_screen_w <= i_cfg_data;
                tlce_pkg::CFG_SCREEN_H: r_screen_h <= i_cfg_data;
                tlce_pkg::CFG_ASCII_W:  r_ascii_w  <= i_cfg_data[6:0];
                tlce_pkg::CFG_ASCII_H:  r_ascii_h  <= i_cfg_data[6:0];
                tlce_pkg::CFG_WIDE_W:   r_wide_w   <= i_cfg_data[6:0];
                tlce_pkg::CFG_WIDE_H:   r_wide_h   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // latched item
    logic [1:0]  r_it_action;
    logic [10:0] r_it_ox, r_it_oy, r_it_lw;
    logic [2:0]  r_it_klen, r_it_wlen;
    logic [7:0]  r_it_b0, r_it_b1, r_it_b2, r_it_b3;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_item) begin
            r_it_action <= i_action;
            r_it_ox     <= i_origin_x;
            r_it_oy     <= i_origin_y;
            r_it_lw     <= i_area_width;
            r_it_klen   <= i_key_length;
            r_it_b0     <= i_byte_0;
            r_it_b1     <= i_byte_1;
            r_it_b2     <= i_byte_2;
            r_it_b3     <= i_byte_3;
            r_it_wlen   <= i_window_length;
        end
    end

    // cursor state
    logic [10:0]   r_col, r_row, r_left, r_right;
    logic          r_halted;
    logic [KW-1:0] r_key_total;
    logic [10:0]   n_col, n_row, n_left, n_right;
    logic          n_halted;
    logic [KW-1:0] n_key_total;

    // key table
    logic [31:0] r_key_bytes [KEY_ENTRIES];
    logic [2:0]  r_key_len   [KEY_ENTRIES];
    logic        mem_we;
    logic [2:0]  load_len;

    // scan
    logic [KW-1:0] r_scan_cnt;
    logic [AW-1:0] r_rd_idx;
    logic [31:0]   r_rd_bytes;
    logic [2:0]    r_rd_len;
    logic          r_rd_vld;
    logic          scan_issue, scan_hit, scan_end, scan_adv;
    logic [2:0]    win_len;
    logic [3:0]    byte_ok;
    logic [AW+6:0] idx_ext;

    // exec arithmetic
    logic [6:0]  line_h, glyph_w;
    logic [11:0] start_sum, row_lh, col_w, row2_lh;
    logic [10:0] row_s, col_a, row_a;
    logic        is_lf, printable, stop0, wrap, stop, is_char, is_wide;

    // output
    logic                 r_out_valid;
    tlce_pkg::t_result    r_out;
    tlce_pkg::t_result    n_res;
    logic                 out_free, out_load;

    always_comb begin
        line_h    = (r_wide_h != 7'd0) ? r_wide_h : r_ascii_h;
        is_lf     = (r_it_b0 == tlce_pkg::CHAR_LF);
        printable = r_it_b0 inside {[tlce_pkg::CHAR_FIRST:tlce_pkg::CHAR_LAST]};
        glyph_w   = printable ? r_ascii_w : r_wide_w;
        start_sum = {1'b0, r_it_ox} + {1'b0, r_it_lw};
        row_lh    = {1'b0, r_row} + {5'b0, line_h};
        stop0     = row_lh > {1'b0, r_screen_h};
        col_w     = {1'b0, r_col} + {5'b0, glyph_w};
        wrap      = !stop0 && (col_w > {1'b0, r_right});
        row_s     = tlce_pkg::sat_add(r_row, {4'b0, line_h});
        row2_lh   = {1'b0, row_s} + {5'b0, line_h};
        stop      = stop0 || (wrap && (row2_lh > {1'b0, r_screen_h}));
        col_a     = wrap ? r_left : r_col;
        row_a     = wrap ? row_s : r_row;
        is_char   = (r_it_action == tlce_pkg::ACT_CHAR);
        is_wide   = is_char && !r_halted && !is_lf && !printable && !stop;
        load_len  = r_it_klen;
        if (load_len == 3'd0) begin
            load_len = 3'd1;
        end
        if (load_len > 3'(KCAP)) begin
            load_len = 3'(KCAP);
        end
    end

    // key match against the registered read
    always_comb begin
        win_len = r_it_wlen;
        if (win_len == 3'd0) begin
            win_len = 3'd1;
        end
        if (win_len > 3'd4) begin
            win_len = 3'd4;
        end
        byte_ok[0] = (r_rd_len <= 3'd0) || (r_rd_bytes[7:0]   == r_it_b0);
        byte_ok[1] = (r_rd_len <= 3'd1) || (r_rd_bytes[15:8]  == r_it_b1);
        byte_ok[2] = (r_rd_len <= 3'd2) || (r_rd_bytes[23:16] == r_it_b2);
        byte_ok[3] = (r_rd_len <= 3'd3) || (r_rd_bytes[31:24] == r_it_b3);
        scan_hit   = r_rd_vld && (r_rd_len != 3'd0) && (r_rd_len <= win_len) && (&byte_ok);
        scan_issue = r_scan_cnt < r_key_total;
        scan_end   = !scan_issue && !r_rd_vld;
        scan_adv   = i_ctl.scan && !scan_hit && !scan_end;
        idx_ext    = {7'b0, r_rd_idx};
    end

    always_comb begin
        out_free          = !r_out_valid || i_out_ready;
        o_sts.is_wide     = is_wide;
        o_sts.scan_done   = scan_hit || scan_end;
        o_sts.out_free    = out_free;
    end

    // next state and result
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_left      = r_left;
        n_right     = r_right;
        n_halted    = r_halted;
        n_key_total = r_key_total;
        mem_we      = 1'b0;
        n_res       = '0;
        n_res.command = tlce_pkg::CMD_NONE;
        if (i_ctl.exec) begin
            case (r_it_action)
                tlce_pkg::ACT_START: begin
                    n_left   = r_it_ox;
                    n_col    = r_it_ox;
                    n_row    = r_it_oy;
                    n_halted = 1'b0;
                    if ((r_it_lw == 11'd0) || (start_sum > {1'b0, r_screen_w})) begin
                        n_right = r_screen_w;
                    end else begin
                        n_right = start_sum[10:0];
                    end
                end
                tlce_pkg::ACT_LOAD: begin
                    if (r_key_total >= KW'(KEY_ENTRIES)) begin
                        n_res.command = tlce_pkg::CMD_FULL;
                    end else begin
                        mem_we      = 1'b1;
                        n_key_total = r_key_total + KW'(1);
                    end
                end
                tlce_pkg::ACT_CLEAR: begin
                    n_key_total = '0;
                end
                default: begin
                    if (r_halted) begin
                        n_res.command = tlce_pkg::CMD_STOPPED;
                    end else if (is_lf) begin
                        n_col                = r_left;
                        n_row                = row_s;
                        n_res.bytes_consumed = 3'd1;
                    end else begin
                        n_col = col_a;
                        n_row = row_a;
                        if (stop) begin
                            n_halted      = 1'b1;
                            n_res.command = tlce_pkg::CMD_STOPPED;
                        end else if (printable) begin
                            n_res.command        = tlce_pkg::CMD_ASCII;
                            n_res.draw_x         = col_a;
                            n_res.draw_y         = row_a;
                            n_res.glyph_width    = r_ascii_w;
                            n_res.glyph_height   = r_ascii_h;
                            n_res.glyph_index    = 7'(r_it_b0 - tlce_pkg::CHAR_FIRST);
                            n_res.bytes_consumed = 3'd1;
                            n_col = tlce_pkg::sat_add(col_a, {4'b0, r_ascii_w});
                        end
                    end
                end
            endcase
        end else if (i_ctl.finish) begin
            n_res.draw_x       = r_col;
            n_res.draw_y       = r_row;
            n_res.glyph_width  = r_wide_w;
            n_res.glyph_height = r_wide_h;
            if (scan_hit) begin
                n_res.command        = tlce_pkg::CMD_TABLE;
                n_res.glyph_index    = idx_ext[6:0];
                n_res.bytes_consumed = r_rd_len;
            end else begin
                n_res.command        = tlce_pkg::CMD_MISSING;
                n_res.bytes_consumed = 3'd1;
            end
            n_col = tlce_pkg::sat_add(r_col, {4'b0, r_wide_w});
        end
        n_res.end_x = n_col;
        n_res.end_y = n_row;
        out_load    = i_ctl.finish || (i_ctl.exec && !is_wide);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= '0;
            r_right     <= '0;
            r_halted    <= 1'b0;
            r_key_total <= '0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_left      <= n_left;
            r_right     <= n_right;
            r_halted    <= n_halted;
            r_key_total <= n_key_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_key_bytes[r_key_total[AW-1:0]] <= {r_it_b3, r_it_b2, r_it_b1, r_it_b0};
            r_key_len[r_key_total[AW-1:0]]   <= load_len;
        end
        if (scan_adv && scan_issue) begin
            r_rd_bytes <= r_key_bytes[r_scan_cnt[AW-1:0]];
            r_rd_len   <= r_key_len[r_scan_cnt[AW-1:0]];
            r_rd_idx   <= r_scan_cnt[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
            r_rd_vld   <= 1'b0;
        end else if (i_ctl.exec) begin
            r_scan_cnt <= '0;
            r_rd_vld   <= 1'b0;
        end else if (scan_adv) begin
            r_rd_vld <= scan_issue;
            if (scan_issue) begin
                r_scan_cnt <= r_scan_cnt + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== hw/rtl/text_layout_cursor_engine_top.sv =====
// Text layout engine with a wrapping cursor. Items are taken one at a time.
// Start, load, clear, newline and ASCII or stopped character items are done
// in the execute state; a wide character then scans the key table, whose
// memory is read one entry per cycle in a sequential prefix scan, and yields
// the first table slot that matches or, if it misses every key, a missing
// result. A finished result sits in an output register; the next item is
// accepted while it waits to be taken, but that item's own result then waits
// inside the block until the register is free. Configuration writes are taken
// in any cycle and are expected only while the block is idle.
module text_layout_cursor_engine_top #(
    parameter int KEY_ENTRIES   = 64,
    parameter int KEY_MAX_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [10:0] i_origin_x,
    input  logic [10:0] i_origin_y,
    input  logic [10:0] i_area_width,
    input  logic [2:0]  i_key_length,
    input  logic [7:0]  i_byte_0,
    input  logic [7:0]  i_byte_1,
    input  logic [7:0]  i_byte_2,
    input  logic [7:0]  i_byte_3,
    input  logic [2:0]  i_window_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_command,
    output logic [10:0] o_draw_x,
    output logic [10:0] o_draw_y,
    output logic [6:0]  o_glyph_width,
    output logic [6:0]  o_glyph_height,
    output logic [6:0]  o_glyph_index,
    output logic [2:0]  o_bytes_consumed,
    output logic [10:0] o_end_x,
    output logic [10:0] o_end_y
);

    tlce_pkg::t_ctl    ctl;
    tlce_pkg::t_sts    sts;
    tlce_pkg::t_result res;

    assign o_cfg_ready = 1'b1;

    tlce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    tlce_dp #(
        .KEY_ENTRIES   (KEY_ENTRIES),
        .KEY_MAX_BYTES (KEY_MAX_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_area_width    (i_area_width),
        .i_key_length    (i_key_length),
        .i_byte_0        (i_byte_0),
        .i_byte_1        (i_byte_1),
        .i_byte_2        (i_byte_2),
        .i_byte_3        (i_byte_3),
        .i_window_length (i_window_length),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_res           (res)
    );

    assign o_command        = res.command;
    assign o_draw_x         = res.draw_x;
    assign o_draw_y         = res.draw_y;
    assign o_glyph_width    = res.glyph_width;
    assign o_glyph_height   = res.glyph_height;
    assign o_glyph_index    = res.glyph_index;
    assign o_bytes_consumed = res.bytes_consumed;
    assign o_end_x          = res.end_x;
    assign o_end_y          = res.end_y;

endmodule
